// ===== src/rcam_pkg.sv =====
// Shared constants and types for the rounded-corner alpha mask block.
`default_nettype none
package rcam_pkg;
    localparam int MaxRadius = 64;
    localparam int MaxWidth  = 2048;
    localparam int AddrW     = 12;

    localparam logic [0:0] FUNC_RENDER = 1'b0;
    localparam logic [0:0] FUNC_READ   = 1'b1;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_RADIUS = 1'b1;

    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [7:0]       wdata;
    } wr_req_t;
endpackage
`default_nettype wire

// ===== src/rcam_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module rcam_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [29:0] value,
    output logic             done,
    output logic [14:0]      root
);
    logic [29:0] v_reg, v_next;
    logic [30:0] res_reg, res_next;
    logic [30:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] trial;

    assign trial = {1'b0, bit_reg} + {1'b0, res_reg};
    assign done  = done_reg;
    assign root  = res_reg[14:0];

    always_comb begin
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            v_next = value;
            res_next = '0;
            bit_next = 31'h4000_0000;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (bit_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if ({2'b0, v_reg} >= trial) begin
                    v_next = 30'({2'b0, v_reg} - trial);
                    res_next = 31'(({1'b0, res_reg} + {bit_reg, 1'b0}) >> 1);
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        v_reg <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end
endmodule
`default_nettype wire

// ===== src/rcam_store.sv =====
// Alpha store: one write port, one registered read port.
`default_nettype none
module rcam_store (
    input  wire logic                     aclk,
    input  wire rcam_pkg::wr_req_t        wr,
    input  wire logic [rcam_pkg::AddrW-1:0] raddr,
    output logic [7:0]                    rdata
);
    logic [7:0] mem [rcam_pkg::MaxRadius*rcam_pkg::MaxRadius];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.waddr] <= wr.wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/rcam_render.sv =====
// Render sequencer: clears the store, two sector passes, square fill.
`default_nettype none
module rcam_render (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [6:0]  radius,
    output logic             idle,
    output logic             done,
    output rcam_pkg::wr_req_t wr
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_ROOT  = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;
    localparam logic [2:0] ST_SQ    = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;
    localparam logic [2:0] ST_INIT  = 3'd7;

    logic [2:0] st_reg, st_next;
    logic [6:0] r_reg, r_next, diag_reg, diag_next, lim_reg, lim_next;
    logic [6:0] i_reg, i_next, j_reg, j_next;
    logic       pass_reg, pass_next;   // 0 row-wise, 1 column-wise
    logic [6:0] c_reg, c_next;
    logic [7:0] frac_reg, frac_next;
    logic       sq_start, sq_done;
    logic [14:0] sq_root;
    logic [29:0] sq_val;
    logic [16:0] prod;
    logic [13:0] rsq, dsq;
    logic [30:0] recip;

    // floor(p/1000) is taken as (p*8389)>>23, which is exact for every
    // product radius*707 that can occur here.
    assign prod  = 17'(radius) * 17'd707;
    assign recip = 31'(prod) * 31'd8389;

    // (r*256)^2 - (d*256)^2 = (r^2 - d^2) << 16
    assign rsq = 14'(r_reg) * 14'(r_reg);
    assign dsq = 14'(i_reg) * 14'(i_reg);
    assign sq_val = {14'(rsq - dsq), 16'b0};
    assign sq_start = (st_reg == ST_ROOT);

    rcam_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .value(sq_val),
        .done(sq_done), .root(sq_root)
    );

    assign idle = (st_reg == ST_IDLE);
    assign done = (st_reg == ST_DONE);

    always_comb begin
        st_next = st_reg;
        r_next = r_reg;
        diag_next = diag_reg;
        lim_next = lim_reg;
        i_next = i_reg;
        j_next = j_reg;
        pass_next = pass_reg;
        c_next = c_reg;
        frac_next = frac_reg;
        wr.we = 1'b0;
        wr.waddr = '0;
        wr.wdata = '0;
        unique case (st_reg)
            ST_INIT: begin
                // After reset every entry of the store is cleared once.
                wr.we = 1'b1;
                wr.waddr = {i_reg[5:0], j_reg[5:0]};
                if (j_reg == 7'(rcam_pkg::MaxRadius - 1)) begin
                    j_next = '0;
                    if (i_reg == 7'(rcam_pkg::MaxRadius - 1)) begin
                        i_next = '0;
                        st_next = ST_IDLE;
                    end else begin
                        i_next = i_reg + 7'd1;
                    end
                end else begin
                    j_next = j_reg + 7'd1;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    r_next = radius;
                    diag_next = 7'(recip[30:23] + 8'd1);
                    lim_next = (7'(recip[30:23] + 8'd1) < radius) ?
                               7'(recip[30:23] + 8'd1) : radius;
                    i_next = '0;
                    j_next = '0;
                    pass_next = 1'b0;
                    st_next = (radius == '0) ? ST_DONE : ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                wr.we = 1'b1;
                wr.waddr = {i_reg[5:0], j_reg[5:0]};
                if (j_reg == r_reg - 7'd1) begin
                    j_next = '0;
                    if (i_reg == r_reg - 7'd1) begin
                        i_next = 7'd1;
                        st_next = (lim_reg > 7'd1) ? ST_ROOT : ST_SQ;
                        if (lim_reg <= 7'd1) begin
                            i_next = diag_reg;
                            j_next = diag_reg;
                            if (diag_reg >= r_reg) st_next = ST_DONE;
                        end
                    end else begin
                        i_next = i_reg + 7'd1;
                    end
                end else begin
                    j_next = j_reg + 7'd1;
                end
            end
            ST_ROOT: st_next = ST_WAIT;
            ST_WAIT: begin
                if (sq_done) begin
                    // c < r always, so it fits 7 bits
                    c_next = sq_root[14:8];
                    frac_next = 8'hff - sq_root[7:0];
                    j_next = sq_root[14:8];
                    st_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (j_reg < r_reg) begin
                    wr.we = 1'b1;
                    wr.wdata = (j_reg == c_reg) ? frac_reg : 8'hff;
                    wr.waddr = pass_reg ? {j_reg[5:0], i_reg[5:0]}
                                        : {i_reg[5:0], j_reg[5:0]};
                end
                if (j_reg + 7'd1 >= r_reg || j_reg >= r_reg) begin
                    if (i_reg + 7'd1 < lim_reg) begin
                        i_next = i_reg + 7'd1;
                        st_next = ST_ROOT;
                    end else if (!pass_reg) begin
                        pass_next = 1'b1;
                        i_next = 7'd1;
                        st_next = ST_ROOT;
                    end else begin
                        i_next = diag_reg;
                        j_next = diag_reg;
                        st_next = (diag_reg >= r_reg) ? ST_DONE : ST_SQ;
                    end
                end else begin
                    j_next = j_reg + 7'd1;
                end
            end
            ST_SQ: begin
                wr.we = 1'b1;
                wr.wdata = 8'hff;
                wr.waddr = {i_reg[5:0], j_reg[5:0]};
                if (j_reg == r_reg - 7'd1) begin
                    j_next = diag_reg;
                    if (i_reg == r_reg - 7'd1) st_next = ST_DONE;
                    else i_next = i_reg + 7'd1;
                end else begin
                    j_next = j_reg + 7'd1;
                end
            end
            ST_DONE: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_INIT;
            i_reg <= '0;
            j_reg <= '0;
        end else begin
            st_reg <= st_next;
            i_reg <= i_next;
            j_reg <= j_next;
        end
        r_reg <= r_next;
        diag_reg <= diag_next;
        lim_reg <= lim_next;
        pass_reg <= pass_next;
        c_reg <= c_next;
        frac_reg <= frac_next;
    end
endmodule
`default_nettype wire

// ===== src/rounded_corner_alpha_mask_top.sv =====
// Top level of the rounded-corner alpha mask block.
//
// The s_ channel carries one transaction per request: tuser is func (0 render,
// 1 read) and tdata holds pixel_x, pixel_row and layer_sel. Each transaction
// yields exactly one m_ transaction: tdata carries alpha_out and out_of_range,
// and tuser is render_done.
// A read is mapped onto a store address, which is presented to the store's
// registered read port in its acceptance cycle; the data is captured in
// ST_READ and offered in ST_OUT. Reads are served one at a time: no new
// transaction is accepted until the result has been taken.
// A render clears radius*radius entries, then runs one square root per
// sector line and writes that line's pixels, and finally fills the
// remaining square.
// Reset (aresetn low, synchronous) returns the registers to width 1080 and
// radius 32 and then clears all 4096 store entries, one per cycle; s_tready
// stays low until that clearing is finished.
// When the receiver stalls, the result is held in the output register and
// no new transaction is accepted until it is taken.
// Configuration writes use cfg_valid/cfg_ready with an index and data; they
// are always accepted and should be issued only while the block is idle.
`default_nettype none
module rounded_corner_alpha_mask_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pixel_x[10:0], pixel_row[16:11], layer_sel[17]
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // alpha_out[7:0], out_of_range[8]
    output logic             m_tuser,   // render_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_RENDER = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0]  st_reg, st_next;
    logic [11:0] width_reg;
    logic [6:0]  radius_reg;
    logic [7:0]  alpha_reg, alpha_next;
    logic        rdone_reg, rdone_next, oor_reg, oor_next, zero_reg, zero_next;
    logic [11:0] raddr_reg, raddr_next;
    logic [7:0]  rdata;
    logic        rnd_start, rnd_done, rnd_idle;
    rcam_pkg::wr_req_t wr;

    logic [10:0] px;
    logic [5:0]  prow;
    logic        top;
    logic [11:0] w_eff;
    logic [6:0]  r_eff;
    logic [6:0]  srow;
    logic [12:0] xr;

    assign px   = s_tdata[10:0];
    assign prow = s_tdata[16:11];
    assign top  = s_tdata[17];
    assign w_eff = (width_reg > 12'(rcam_pkg::MaxWidth)) ? 12'(rcam_pkg::MaxWidth) : width_reg;
    assign r_eff = (radius_reg > 7'(rcam_pkg::MaxRadius)) ? 7'(rcam_pkg::MaxRadius) : radius_reg;
    assign srow = top ? (r_eff - 7'd1 - 7'(prow)) : 7'(prow);
    assign xr   = 13'(px) + 13'(r_eff);

    // The render sequencer is not idle while it clears the store after reset.
    assign cfg_ready = 1'b1;
    assign s_tready  = (st_reg == ST_IDLE) && rnd_idle;
    assign m_tvalid  = (st_reg == ST_OUT);
    assign m_tdata   = {7'b0, oor_reg, alpha_reg};
    assign m_tuser   = rdone_reg;
    assign rnd_start = s_tvalid && s_tready && (s_tuser == rcam_pkg::FUNC_RENDER);

    // The read address is presented in the acceptance cycle so that the
    // store data is ready in ST_READ.
    rcam_store u_store (.aclk(aclk), .wr(wr), .raddr(raddr_next), .rdata(rdata));
    rcam_render u_render (
        .aclk(aclk), .aresetn(aresetn), .start(rnd_start), .radius(r_eff),
        .idle(rnd_idle), .done(rnd_done), .wr(wr)
    );

    always_comb begin
        st_next = st_reg;
        alpha_next = alpha_reg;
        rdone_next = rdone_reg;
        oor_next = oor_reg;
        zero_next = zero_reg;
        raddr_next = raddr_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser == rcam_pkg::FUNC_RENDER) begin
                        st_next = ST_RENDER;
                    end else begin
                        rdone_next = 1'b0;
                        oor_next = (12'(px) >= w_eff) || (7'(prow) >= r_eff);
                        zero_next = 1'b1;
                        raddr_next = '0;
                        if (12'(px) < 12'(r_eff)) begin
                            zero_next = 1'b0;
                            raddr_next = {srow[5:0], 6'(r_eff - 7'd1 - 7'(px))};
                        end else if (xr >= 13'(w_eff)) begin
                            zero_next = 1'b0;
                            raddr_next = {srow[5:0], 6'(xr - 13'(w_eff))};
                        end
                        st_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                alpha_next = (zero_reg || oor_reg) ? 8'd0 : rdata;
                st_next = ST_OUT;
            end
            ST_RENDER: begin
                if (rnd_done) begin
                    alpha_next = '0;
                    rdone_next = 1'b1;
                    oor_next = 1'b0;
                    st_next = ST_OUT;
                end
            end
            ST_OUT: if (m_tready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            width_reg <= 12'd1080;
            radius_reg <= 7'd32;
        end else begin
            st_reg <= st_next;
            if (cfg_valid && cfg_index == rcam_pkg::CFG_WIDTH) width_reg <= cfg_data;
            if (cfg_valid && cfg_index == rcam_pkg::CFG_RADIUS) radius_reg <= cfg_data[6:0];
        end
        alpha_reg <= alpha_next;
        rdone_reg <= rdone_next;
        oor_reg <= oor_next;
        zero_reg <= zero_next;
        raddr_reg <= raddr_next;
    end
endmodule
`default_nettype wire
